>>> rtl/fir_conv_pkg.sv
// Package: sizes, codes, command and status types for the FIR convolution block.
package fir_conv_pkg;

   localparam int MAX_TAPS     = 32;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 16;
   localparam int TAPS_WIDTH   = 6;
   localparam int INDEX_WIDTH  = 5;
   localparam int OUT_WIDTH    = 37;
   localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int TAP_W        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CNT_W        = $clog2(MAX_TAPS + 1);

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef struct packed {
      logic             shift_en;
      logic             shift_zero;
      logic             line_clear;
      logic             coef_wr;
      logic             mac_issue;
      logic [TAP_W-1:0] mac_index;
      logic             acc_clear;
      logic             out_load;
      logic             out_last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [CNT_W-1:0] sat_taps(input logic [TAPS_WIDTH-1:0] tc);
      logic [CNT_W-1:0] r;
      if (int'(tc) > MAX_TAPS) begin
         r = CNT_W'(MAX_TAPS);
      end else if (tc == '0) begin
         r = CNT_W'(1);
      end else begin
         r = CNT_W'(tc);
      end
      return r;
   endfunction

endpackage

>>> rtl/fir_conv_datapath.sv
// Datapath: delay line, coefficient store, multiplier, accumulator and output register.
module fir_conv_datapath
   import fir_conv_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   output status_type                     status,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic [INDEX_WIDTH-1:0]         req_coef_index,
   input  logic signed [COEF_WIDTH-1:0]   req_coef_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [OUT_WIDTH-1:0]    rsp_out_value,
   output logic                           rsp_out_last
);

   logic signed [SAMPLE_WIDTH-1:0] line_ff [MAX_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] line_in [MAX_TAPS];
   logic signed [COEF_WIDTH-1:0]   coef_ff [MAX_TAPS];
   logic signed [PROD_WIDTH-1:0]   prod_ff;
   logic signed [PROD_WIDTH-1:0]   prod_in;
   logic                           prod_vld_ff;
   logic signed [OUT_WIDTH-1:0]    acc_ff;
   logic signed [OUT_WIDTH-1:0]    acc_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic signed [OUT_WIDTH-1:0]    out_value_ff;
   logic                           out_last_ff;

   // shift, insert zero for the tail, or clear at the end of a signal
   always_comb begin
      for (int i = 0; i < MAX_TAPS; i++) begin
         line_in[i] = line_ff[i];
      end
      if (cmd.line_clear) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            line_in[i] = '0;
         end
      end else if (cmd.shift_en) begin
         for (int i = MAX_TAPS - 1; i > 0; i--) begin
            line_in[i] = line_ff[i-1];
         end
         line_in[0] = cmd.shift_zero ? '0 : req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            line_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            line_ff[i] <= line_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (cmd.coef_wr && (int'(req_coef_index) < MAX_TAPS)) begin
         coef_ff[TAP_W'(req_coef_index)] <= req_coef_value;
      end
   end

   assign prod_in = line_ff[cmd.mac_index] * coef_ff[cmd.mac_index];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mac_issue;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + OUT_WIDTH'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_value_ff <= acc_ff;
         out_last_ff  <= cmd.out_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_out_last  = out_last_ff;

endmodule

>>> rtl/fir_conv_ctrl.sv
// Controller: tap count register and sequencer for the multiply-accumulate passes.
module fir_conv_ctrl
   import fir_conv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic                  req_last_sample,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [TAPS_WIDTH-1:0] csr_tap_count,
   output cmd_type               cmd,
   input  status_type            status
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MAC   = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [TAPS_WIDTH-1:0] tap_count_ff;
   logic [CNT_W-1:0]      taps_ff, taps_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [TAP_W-1:0]      k_ff, k_in;
   logic                  last_ff, last_in;
   logic                  accept;
   logic                  k_end;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAPS_WIDTH'(MAX_TAPS);
      end else if (csr_valid) begin
         tap_count_ff <= csr_tap_count;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign k_end     = (CNT_W'(k_ff) == taps_ff - CNT_W'(1));

   always_comb begin
      state_in = state_ff;
      taps_in  = taps_ff;
      rem_in   = rem_ff;
      k_in     = k_ff;
      last_in  = last_ff;
      cmd      = '0;
      cmd.mac_index = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_SAMPLE) begin
                  taps_in = sat_taps(tap_count_ff);
                  rem_in  = req_last_sample ? sat_taps(tap_count_ff) - CNT_W'(1) : '0;
                  last_in = req_last_sample;
                  k_in    = '0;
                  cmd.shift_en  = 1'b1;
                  cmd.acc_clear = 1'b1;
                  state_in = S_MAC;
               end else begin
                  cmd.coef_wr = 1'b1;
               end
            end
         end
         S_MAC: begin
            cmd.mac_issue = 1'b1;
            if (k_end) begin
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + TAP_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = last_ff && (rem_ff == '0);
               if (rem_ff != '0) begin
                  rem_in = rem_ff - CNT_W'(1);
                  k_in   = '0;
                  cmd.shift_en   = 1'b1;
                  cmd.shift_zero = 1'b1;
                  cmd.acc_clear  = 1'b1;
                  state_in = S_MAC;
               end else begin
                  cmd.line_clear = last_ff;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         taps_ff  <= CNT_W'(1);
         rem_ff   <= '0;
         k_ff     <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         taps_ff  <= taps_in;
         rem_ff   <= rem_in;
         k_ff     <= k_in;
         last_ff  <= last_in;
      end
   end

   a_sample_starts_mac: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_SAMPLE) |=> (state_ff == S_MAC && k_ff == '0))
      else $error("sample word did not start a multiply pass at tap zero");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC) |-> (CNT_W'(k_ff) < taps_ff))
      else $error("tap index beyond taps in use");

   a_tail_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (rem_ff < taps_ff))
      else $error("tail count exceeds taps in use");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output register overwritten while full");

   a_drain_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |=> (state_ff == S_EMIT))
      else $error("drain did not reach emit");

endmodule

>>> rtl/fir_full_convolution.sv
// Top level: FIR full convolution, controller plus datapath.
// A load word (func 0) writes one Q1.15 coefficient and gives no result. A sample word
// (func 1) is shifted into the delay line, then n taps, n the saturated tap count, go
// through the single 16x16 multiplier (one tap per cycle); a drain step finishes the
// accumulate and the output register is loaded once it is free. A sample marked last
// is followed by n - 1 tail results, with zeros shifted in, the final one flagged by
// rsp_out_last, after which the delay line is cleared. The next word is accepted while
// the last result still waits in the output register. The user must write the tap
// count register via csr_ (no wait states) only while idle; the block does not check.
module fir_full_convolution
   import fir_conv_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_last_sample,
   input  logic [INDEX_WIDTH-1:0]         req_coef_index,
   input  logic signed [COEF_WIDTH-1:0]   req_coef_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [OUT_WIDTH-1:0]    rsp_out_value,
   output logic                           rsp_out_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [TAPS_WIDTH-1:0]          csr_tap_count
);

   cmd_type    cmd;
   status_type status;

   fir_conv_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_last_sample (req_last_sample),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_tap_count   (csr_tap_count),
      .cmd             (cmd),
      .status          (status)
   );

   fir_conv_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_sample),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_last   (rsp_out_last)
   );

endmodule
